FILE: hw/rtl/ssps_pkg.sv
// shared types, codes and constants of the sounding step phase sequencer
// used by ssps_slot_ctrl, ssps_action_dec and sounding_step_phase_sequencer
// no dependencies

package ssps_pkg;

  // sequencer state, idle plus one state per radio slot
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SYNC_I = 7'b0000010,
    ST_SYNC_R = 7'b0000100,
    ST_TONE_I = 7'b0001000,
    ST_TONE_R = 7'b0010000,
    ST_EXT_I  = 7'b0100000,
    ST_EXT_R  = 7'b1000000
  } state_t;

  // slot code reported on the result channel
  typedef enum logic [2:0] {
    SLOT_SYNC_I = 3'd0,
    SLOT_SYNC_R = 3'd1,
    SLOT_TONE_I = 3'd2,
    SLOT_TONE_R = 3'd3,
    SLOT_EXT_I  = 3'd4,
    SLOT_EXT_R  = 3'd5,
    SLOT_DONE   = 3'd6,
    SLOT_NONE   = 3'd7
  } slot_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_TX_SYNC = 3'd1,
    ACT_RX_SYNC = 3'd2,
    ACT_TX_TONE = 3'd3,
    ACT_RX_TONE = 3'd4,
    ACT_SKIP    = 3'd5
  } action_t;

  // step modes
  localparam logic [1:0] MODE_CAL     = 2'd0;
  localparam logic [1:0] MODE_RTT     = 2'd1;
  localparam logic [1:0] MODE_PBR     = 2'd2;
  localparam logic [1:0] MODE_RTT_PBR = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_ROLE        = 3'd0;
  localparam logic [2:0] CFG_IP1         = 3'd1;
  localparam logic [2:0] CFG_IP2         = 3'd2;
  localparam logic [2:0] CFG_FCS         = 3'd3;
  localparam logic [2:0] CFG_TONE_PERIOD = 3'd4;
  localparam logic [2:0] CFG_SWITCH      = 3'd5;
  localparam logic [2:0] CFG_SYNC        = 3'd6;
  localparam logic [2:0] CFG_SEQUENCE    = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // timing constants, microseconds
  localparam logic [7:0] T_RD        = 8'd5;
  localparam logic [7:0] T_GD        = 8'd10;
  localparam logic [7:0] T_FM        = 8'd80;
  localparam logic [1:0] RX_EARLY_US = 2'd2;
  localparam logic [6:0] SYNC_RESET  = 7'd44;

  typedef struct packed {
    logic       role;
    logic [7:0] interlude_one_us;
    logic [7:0] interlude_two_us;
    logic [7:0] freq_change_us;
    logic [5:0] tone_period_us;
    logic [3:0] switch_time_us;
    logic [6:0] sync_time_us;
    logic [6:0] sequence_time_us;
  } cfg_t;

  typedef struct packed {
    logic       func;
    logic [1:0] mode_sel;
    logic [2:0] antenna_paths;
    logic       ext_present_init;
    logic       ext_present_refl;
  } req_t;

  typedef struct packed {
    slot_t      slot;
    logic [7:0] length_us;
    logic [7:0] gap_us;
    logic       step_done;
    logic       bad_advance;
  } rsp_t;

  function automatic logic [7:0] sat8(input logic [8:0] v);
    sat8 = v[8] ? 8'hFF : v[7:0];
  endfunction

endpackage

FILE: hw/rtl/ssps_action_dec.sv
// role dependent action and early-open decode for one slot
// depends on ssps_pkg

module ssps_action_dec (
  input  ssps_pkg::slot_t   slot,
  input  logic              role,
  input  logic [1:0]        ext_flags,
  output ssps_pkg::action_t action,
  output logic [1:0]        early_us
);

  logic tx_side;

  assign tx_side = (~slot[0]) ^ role;

  always_comb begin
    action   = ssps_pkg::ACT_NONE;
    early_us = 2'd0;
    case (slot)
      ssps_pkg::SLOT_SYNC_I, ssps_pkg::SLOT_SYNC_R: begin
        if (tx_side) begin
          action = ssps_pkg::ACT_TX_SYNC;
        end else begin
          action   = ssps_pkg::ACT_RX_SYNC;
          early_us = ssps_pkg::RX_EARLY_US;
        end
      end
      ssps_pkg::SLOT_TONE_I, ssps_pkg::SLOT_TONE_R: begin
        action = tx_side ? ssps_pkg::ACT_TX_TONE : ssps_pkg::ACT_RX_TONE;
      end
      ssps_pkg::SLOT_EXT_I: begin
        if (!ext_flags[0]) action = ssps_pkg::ACT_SKIP;
        else action = tx_side ? ssps_pkg::ACT_TX_TONE : ssps_pkg::ACT_RX_TONE;
      end
      ssps_pkg::SLOT_EXT_R: begin
        if (!ext_flags[1]) action = ssps_pkg::ACT_SKIP;
        else action = tx_side ? ssps_pkg::ACT_TX_TONE : ssps_pkg::ACT_RX_TONE;
      end
      default: begin
        action   = ssps_pkg::ACT_NONE;
        early_us = 2'd0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ssps_slot_ctrl.sv
// step state and next-slot logic: slot order, lengths and gaps per mode
// depends on ssps_pkg

module ssps_slot_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             commit,
  input  ssps_pkg::req_t   req,
  input  ssps_pkg::cfg_t   cfg,
  output ssps_pkg::rsp_t   rsp,
  output logic [1:0]       ext_flags
);

  ssps_pkg::state_t state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [2:0] paths_left_r, paths_left_nxt;
  logic [2:0] paths_loaded_r, paths_loaded_nxt;
  logic [1:0] ext_r, ext_nxt;

  ssps_pkg::state_t from;
  logic [7:0] ty0, ty1, pm, sw, fin, gap_ip1, gap_ip2;

  assign ty0     = {1'b0, cfg.sync_time_us};
  assign ty1     = {1'b0, cfg.sync_time_us} + {1'b0, cfg.sequence_time_us};
  assign pm      = {2'b00, cfg.tone_period_us};
  assign sw      = {4'h0, cfg.switch_time_us};
  assign fin     = ssps_pkg::sat8({1'b0, ssps_pkg::T_RD} + {1'b0, cfg.freq_change_us});
  assign gap_ip1 = ssps_pkg::sat8({1'b0, ssps_pkg::T_RD} + {1'b0, cfg.interlude_one_us});
  assign gap_ip2 = ssps_pkg::sat8({1'b0, ssps_pkg::T_RD} + {1'b0, cfg.interlude_two_us});

  // a start request reloads the step context
  always_comb begin
    if (req.func) begin
      mode_nxt         = req.mode_sel;
      paths_loaded_nxt = req.antenna_paths;
      ext_nxt          = {req.ext_present_refl, req.ext_present_init};
      from             = ssps_pkg::ST_IDLE;
    end else begin
      mode_nxt         = mode_r;
      paths_loaded_nxt = paths_loaded_r;
      ext_nxt          = ext_r;
      from             = state_r;
    end
  end

  assign ext_flags = ext_nxt;

  always_comb begin
    paths_left_nxt  = req.func ? req.antenna_paths : paths_left_r;
    state_nxt       = ssps_pkg::ST_IDLE;
    rsp.slot        = ssps_pkg::SLOT_DONE;
    rsp.length_us   = 8'd0;
    rsp.gap_us      = fin;
    rsp.step_done   = 1'b0;
    rsp.bad_advance = 1'b0;

    if (!req.func && state_r == ssps_pkg::ST_IDLE) begin
      rsp.slot        = ssps_pkg::SLOT_NONE;
      rsp.gap_us      = 8'd0;
      rsp.bad_advance = 1'b1;
    end else begin
      case (mode_nxt)
        ssps_pkg::MODE_CAL: begin
          case (from)
            ssps_pkg::ST_IDLE: begin
              rsp.slot = ssps_pkg::SLOT_SYNC_I; rsp.length_us = ty0; rsp.gap_us = 8'd0;
            end
            ssps_pkg::ST_SYNC_I: begin
              rsp.slot = ssps_pkg::SLOT_SYNC_R; rsp.length_us = ty0; rsp.gap_us = gap_ip1;
            end
            ssps_pkg::ST_SYNC_R: begin
              rsp.slot      = ssps_pkg::SLOT_TONE_R;
              rsp.length_us = ssps_pkg::T_FM;
              rsp.gap_us    = ssps_pkg::T_GD;
            end
            default: rsp.slot = ssps_pkg::SLOT_DONE;
          endcase
        end
        ssps_pkg::MODE_RTT: begin
          case (from)
            ssps_pkg::ST_IDLE: begin
              rsp.slot = ssps_pkg::SLOT_SYNC_I; rsp.length_us = ty1; rsp.gap_us = 8'd0;
            end
            ssps_pkg::ST_SYNC_I: begin
              rsp.slot = ssps_pkg::SLOT_SYNC_R; rsp.length_us = ty1; rsp.gap_us = gap_ip1;
            end
            default: rsp.slot = ssps_pkg::SLOT_DONE;
          endcase
        end
        default: begin
          case (from)
            ssps_pkg::ST_IDLE: begin
              rsp.gap_us = 8'd0;
              if (mode_nxt == ssps_pkg::MODE_PBR) begin
                rsp.slot = ssps_pkg::SLOT_TONE_I; rsp.length_us = pm;
              end else begin
                rsp.slot = ssps_pkg::SLOT_SYNC_I; rsp.length_us = ty1;
              end
            end
            ssps_pkg::ST_SYNC_I: begin
              if (mode_nxt == ssps_pkg::MODE_RTT_PBR) begin
                rsp.slot      = ssps_pkg::SLOT_TONE_I;
                rsp.length_us = pm;
                rsp.gap_us    = ssps_pkg::T_GD;
              end
            end
            ssps_pkg::ST_TONE_I: begin
              rsp.length_us = pm;
              rsp.gap_us    = sw;
              if (paths_left_r != 3'd0) begin
                paths_left_nxt = paths_left_r - 3'd1;
                rsp.slot       = ssps_pkg::SLOT_TONE_I;
              end else begin
                rsp.slot = ssps_pkg::SLOT_EXT_I;
              end
            end
            ssps_pkg::ST_EXT_I: begin
              paths_left_nxt = paths_loaded_r;
              rsp.slot       = ssps_pkg::SLOT_TONE_R;
              rsp.length_us  = pm;
              rsp.gap_us     = gap_ip2;
            end
            ssps_pkg::ST_TONE_R: begin
              rsp.length_us = pm;
              rsp.gap_us    = sw;
              if (paths_left_r != 3'd0) begin
                paths_left_nxt = paths_left_r - 3'd1;
                rsp.slot       = ssps_pkg::SLOT_TONE_R;
              end else begin
                rsp.slot = ssps_pkg::SLOT_EXT_R;
              end
            end
            ssps_pkg::ST_EXT_R: begin
              paths_left_nxt = paths_loaded_r;
              if (mode_nxt == ssps_pkg::MODE_RTT_PBR) begin
                rsp.slot      = ssps_pkg::SLOT_SYNC_R;
                rsp.length_us = ty1;
                rsp.gap_us    = ssps_pkg::T_RD;
              end
            end
            default: rsp.slot = ssps_pkg::SLOT_DONE;
          endcase
        end
      endcase

      case (rsp.slot)
        ssps_pkg::SLOT_SYNC_I: state_nxt = ssps_pkg::ST_SYNC_I;
        ssps_pkg::SLOT_SYNC_R: state_nxt = ssps_pkg::ST_SYNC_R;
        ssps_pkg::SLOT_TONE_I: state_nxt = ssps_pkg::ST_TONE_I;
        ssps_pkg::SLOT_TONE_R: state_nxt = ssps_pkg::ST_TONE_R;
        ssps_pkg::SLOT_EXT_I:  state_nxt = ssps_pkg::ST_EXT_I;
        ssps_pkg::SLOT_EXT_R:  state_nxt = ssps_pkg::ST_EXT_R;
        default: begin
          state_nxt     = ssps_pkg::ST_IDLE;
          rsp.length_us = 8'd0;
          rsp.step_done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ssps_pkg::ST_IDLE;
      mode_r         <= 2'd0;
      paths_left_r   <= 3'd0;
      paths_loaded_r <= 3'd0;
      ext_r          <= 2'd0;
    end else if (commit && !rsp.bad_advance) begin
      state_r        <= state_nxt;
      mode_r         <= mode_nxt;
      paths_left_r   <= paths_left_nxt;
      paths_loaded_r <= paths_loaded_nxt;
      ext_r          <= ext_nxt;
    end
  end

endmodule

FILE: hw/rtl/sounding_step_phase_sequencer.sv
// Sequencer for the radio slots of one channel-sounding step, modes 0 to 3.
// A start request latches mode, antenna path count and extension flags and
// enters the first slot; each advance request enters the next slot, or is flagged
// bad_advance when no step is active. Every request gives exactly one result. A
// request passes an input register, the next-slot logic and a result register;
// the block takes one request per clock while the output is not stalled. The
// result register decouples the sides, so a stalled output holds one result
// while one more request waits in the input register.
// Depends on ssps_pkg, ssps_slot_ctrl and ssps_action_dec.

module sounding_step_phase_sequencer (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,

  input  logic        in_tvalid,
  output logic        in_tready,
  // mode_sel[1:0], antenna_paths[4:2], ext_present_init[5], ext_present_refl[6]
  input  logic [7:0]  in_tdata,
  // func[0]
  input  logic        in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // slot[2:0], action[5:3], length_us[13:6], gap_us[21:14], early_us[23:22]
  output logic [23:0] out_tdata,
  // step_done
  output logic        out_tlast,
  // bad_advance[0]
  output logic        out_tuser
);

  ssps_pkg::cfg_t    cfg_r;
  ssps_pkg::req_t    req_r;
  ssps_pkg::rsp_t    rsp;
  ssps_pkg::action_t action;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              in_accept;
  logic              advance;
  logic [1:0]        ext_flags;
  logic [1:0]        early_us;
  logic [23:0]       out_data_r;
  logic              out_last_r;
  logic              out_user_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.role             <= 1'b0;
      cfg_r.interlude_one_us <= 8'd0;
      cfg_r.interlude_two_us <= 8'd0;
      cfg_r.freq_change_us   <= 8'd0;
      cfg_r.tone_period_us   <= 6'd0;
      cfg_r.switch_time_us   <= 4'd0;
      cfg_r.sync_time_us     <= ssps_pkg::SYNC_RESET;
      cfg_r.sequence_time_us <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssps_pkg::CFG_ROLE:        cfg_r.role             <= cfg_wdata[0];
        ssps_pkg::CFG_IP1:         cfg_r.interlude_one_us <= cfg_wdata;
        ssps_pkg::CFG_IP2:         cfg_r.interlude_two_us <= cfg_wdata;
        ssps_pkg::CFG_FCS:         cfg_r.freq_change_us   <= cfg_wdata;
        ssps_pkg::CFG_TONE_PERIOD: cfg_r.tone_period_us   <= cfg_wdata[5:0];
        ssps_pkg::CFG_SWITCH:      cfg_r.switch_time_us   <= cfg_wdata[3:0];
        ssps_pkg::CFG_SYNC:        cfg_r.sync_time_us     <= cfg_wdata[6:0];
        ssps_pkg::CFG_SEQUENCE:    cfg_r.sequence_time_us <= cfg_wdata[6:0];
        default: cfg_r.role <= cfg_r.role;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r.func             <= in_tuser;
      req_r.mode_sel         <= in_tdata[1:0];
      req_r.antenna_paths    <= in_tdata[4:2];
      req_r.ext_present_init <= in_tdata[5];
      req_r.ext_present_refl <= in_tdata[6];
    end
  end

  ssps_slot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (advance),
    .req       (req_r),
    .cfg       (cfg_r),
    .rsp       (rsp),
    .ext_flags (ext_flags)
  );

  ssps_action_dec u_action (
    .slot      (rsp.slot),
    .role      (cfg_r.role),
    .ext_flags (ext_flags),
    .action    (action),
    .early_us  (early_us)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {early_us, rsp.gap_us, rsp.length_us, action, rsp.slot};
      out_last_r <= rsp.step_done;
      out_user_r <= rsp.bad_advance;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: sim/sounding_step_phase_sequencer_tb.sv
// testbench for sounding_step_phase_sequencer: random stream traffic with stalls on both sides,
// an in-house slot predictor and an in-order result check; depends on ssps_pkg and the rtl
`timescale 1ns / 1ps

module sounding_step_phase_sequencer_tb;

  typedef struct packed {
    logic [2:0] slot;
    logic [2:0] action;
    logic [7:0] length_us;
    logic [7:0] gap_us;
    logic [1:0] early_us;
    logic       step_done;
    logic       bad_advance;
  } slot_result_t;

  class slot_sequence_checker;
    bit              role;
    int unsigned     ip1, ip2, fcs, tone_pm, sw_us, sync_us, seq_us;
    ssps_pkg::slot_t cur;
    logic [1:0]      mode;
    logic [2:0]      paths_left, paths_loaded;
    logic [1:0]      ext_flags;
    slot_result_t    expected_slots[$];
    int unsigned     failures;

    function new();
      role = 1'b0; ip1 = 0; ip2 = 0; fcs = 0; tone_pm = 0; sw_us = 0;
      sync_us = ssps_pkg::SYNC_RESET; seq_us = 0;
      cur = ssps_pkg::SLOT_NONE; mode = '0; paths_left = '0; paths_loaded = '0;
      ext_flags = '0;
      failures = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] v);
      case (idx)
        ssps_pkg::CFG_ROLE:        role = v[0];
        ssps_pkg::CFG_IP1:         ip1 = v;
        ssps_pkg::CFG_IP2:         ip2 = v;
        ssps_pkg::CFG_FCS:         fcs = v;
        ssps_pkg::CFG_TONE_PERIOD: tone_pm = v[5:0];
        ssps_pkg::CFG_SWITCH:      sw_us = v[3:0];
        ssps_pkg::CFG_SYNC:        sync_us = v[6:0];
        ssps_pkg::CFG_SEQUENCE:    seq_us = v[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_slots.size();
    endfunction

    // repeats the tone slot once per remaining path, then enters the extension
    function ssps_pkg::slot_t tone_repeat(ssps_pkg::slot_t here, ssps_pkg::slot_t ext,
                                          output int unsigned len, output int unsigned gap);
      len = tone_pm;
      gap = sw_us;
      if (paths_left != 3'd0) begin
        paths_left = paths_left - 3'd1;
        return here;
      end
      return ext;
    endfunction

    function ssps_pkg::slot_t next_slot(ssps_pkg::slot_t from, output int unsigned len,
                                        output int unsigned gap);
      int unsigned ty0, ty1;
      ty0 = sync_us;
      ty1 = sync_us + seq_us;
      len = 0;
      gap = ssps_pkg::T_RD + fcs;
      case (mode)
        ssps_pkg::MODE_CAL: begin
          if (from == ssps_pkg::SLOT_NONE) begin
            len = ty0; gap = 0; return ssps_pkg::SLOT_SYNC_I;
          end
          if (from == ssps_pkg::SLOT_SYNC_I) begin
            len = ty0; gap = ssps_pkg::T_RD + ip1; return ssps_pkg::SLOT_SYNC_R;
          end
          if (from == ssps_pkg::SLOT_SYNC_R) begin
            len = ssps_pkg::T_FM; gap = ssps_pkg::T_GD; return ssps_pkg::SLOT_TONE_R;
          end
        end
        ssps_pkg::MODE_RTT: begin
          if (from == ssps_pkg::SLOT_NONE) begin
            len = ty1; gap = 0; return ssps_pkg::SLOT_SYNC_I;
          end
          if (from == ssps_pkg::SLOT_SYNC_I) begin
            len = ty1; gap = ssps_pkg::T_RD + ip1; return ssps_pkg::SLOT_SYNC_R;
          end
        end
        default: begin
          if (from == ssps_pkg::SLOT_NONE) begin
            gap = 0;
            if (mode == ssps_pkg::MODE_PBR) begin
              len = tone_pm; return ssps_pkg::SLOT_TONE_I;
            end
            len = ty1;
            return ssps_pkg::SLOT_SYNC_I;
          end
          if (from == ssps_pkg::SLOT_SYNC_I && mode == ssps_pkg::MODE_RTT_PBR) begin
            len = tone_pm; gap = ssps_pkg::T_GD; return ssps_pkg::SLOT_TONE_I;
          end
          if (from == ssps_pkg::SLOT_TONE_I)
            return tone_repeat(ssps_pkg::SLOT_TONE_I, ssps_pkg::SLOT_EXT_I, len, gap);
          if (from == ssps_pkg::SLOT_EXT_I) begin
            paths_left = paths_loaded;
            len = tone_pm;
            gap = ssps_pkg::T_RD + ip2;
            return ssps_pkg::SLOT_TONE_R;
          end
          if (from == ssps_pkg::SLOT_TONE_R)
            return tone_repeat(ssps_pkg::SLOT_TONE_R, ssps_pkg::SLOT_EXT_R, len, gap);
          if (from == ssps_pkg::SLOT_EXT_R) begin
            paths_left = paths_loaded;
            if (mode == ssps_pkg::MODE_RTT_PBR) begin
              len = ty1; gap = ssps_pkg::T_RD; return ssps_pkg::SLOT_SYNC_R;
            end
          end
        end
      endcase
      return ssps_pkg::SLOT_DONE;
    endfunction

    // returns the predicted step_done flag of the request
    function bit note_request(logic func, logic [1:0] mode_sel, logic [2:0] paths,
                              logic ext_i, logic ext_r);
      slot_result_t    r;
      ssps_pkg::slot_t from, to;
      int unsigned     len, gap;
      bit              tx_side;
      r = '0;
      if (func) begin
        mode = mode_sel;
        paths_loaded = paths;
        paths_left = paths;
        ext_flags = {ext_r, ext_i};
        from = ssps_pkg::SLOT_NONE;
      end else if (cur == ssps_pkg::SLOT_NONE) begin
        r.slot = ssps_pkg::SLOT_NONE;
        r.bad_advance = 1'b1;
        expected_slots.push_back(r);
        return 1'b0;
      end else begin
        from = cur;
      end
      to = next_slot(from, len, gap);
      r.slot = to;
      r.gap_us = (gap > 255) ? 8'hFF : gap[7:0];
      if (to == ssps_pkg::SLOT_DONE) begin
        r.step_done = 1'b1;
        cur = ssps_pkg::SLOT_NONE;
      end else begin
        r.length_us = (len > 255) ? 8'hFF : len[7:0];
        cur = to;
      end
      if (to <= ssps_pkg::SLOT_EXT_R) begin
        tx_side = (to[0] == 1'b0) != role;
        if ((to == ssps_pkg::SLOT_EXT_I && !ext_flags[0]) ||
            (to == ssps_pkg::SLOT_EXT_R && !ext_flags[1]))
          r.action = ssps_pkg::ACT_SKIP;
        else if (to <= ssps_pkg::SLOT_SYNC_R) begin
          r.action = tx_side ? ssps_pkg::ACT_TX_SYNC : ssps_pkg::ACT_RX_SYNC;
          r.early_us = tx_side ? 2'd0 : ssps_pkg::RX_EARLY_US;
        end else
          r.action = tx_side ? ssps_pkg::ACT_TX_TONE : ssps_pkg::ACT_RX_TONE;
      end
      expected_slots.push_back(r);
      return r.step_done;
    endfunction

    function void check_result(logic [23:0] data, logic last, logic user);
      slot_result_t want, got;
      got.slot = data[2:0];
      got.action = data[5:3];
      got.length_us = data[13:6];
      got.gap_us = data[21:14];
      got.early_us = data[23:22];
      got.step_done = last;
      got.bad_advance = user;
      if (expected_slots.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result with nothing expected: slot %0d act %0d len %0d gap %0d",
                   got.slot, got.action, got.length_us, got.gap_us);
        return;
      end
      want = expected_slots.pop_front();
      if (want.slot != got.slot || want.action != got.action ||
          want.length_us != got.length_us || want.gap_us != got.gap_us ||
          want.early_us != got.early_us || want.step_done != got.step_done ||
          want.bad_advance != got.bad_advance) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch at %0t: expected slot %0d act %0d len %0d gap %0d",
                   $realtime, want.slot, want.action, want.length_us, want.gap_us,
                   " early %0d done %0d bad %0d",
                   want.early_us, want.step_done, want.bad_advance);
          $display("  got slot %0d act %0d len %0d gap %0d early %0d done %0d bad %0d",
                   got.slot, got.action, got.length_us, got.gap_us, got.early_us,
                   got.step_done, got.bad_advance);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  slot_sequence_checker board = new();
  logic [7:0]  regs [8];
  int unsigned requests_sent = 0;
  int unsigned in_idle_pct = 20;
  int unsigned out_idle_pct = 20;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  sounding_step_phase_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: check every accepted result, stall in bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata, out_tlast, out_tuser);
    if (stall_left > 0)
      stall_left--;
    else if (!calm && $urandom_range(0, 99) < out_idle_pct)
      stall_left = $urandom_range(1, 5);
    out_tready <= (stall_left == 0);
    cycle_count++;
    if (cycle_count % 64 == 0)
      case ($urandom_range(0, 2))
        0: out_idle_pct = 0;
        1: out_idle_pct = 15;
        default: out_idle_pct = 40;
      endcase
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_request(input logic func, input logic [1:0] m, input logic [2:0] p,
                              input logic ei, input logic er, output bit step_done);
    if (!calm && in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {1'b0, er, ei, p, m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_done = board.note_request(func, m, p, ei, er);
    requests_sent++;
  endtask

  task automatic run_full(input logic [1:0] m, input logic [2:0] p, input logic ei,
                          input logic er);
    bit step_done;
    send_request(1'b1, m, p, ei, er, step_done);
    while (!step_done) send_request(1'b0, '0, '0, 1'b0, 1'b0, step_done);
  endtask

  // mostly whole steps with random content, some cut short, some stray advances
  task automatic run_step();
    bit         step_done;
    int         kind, cut;
    logic [2:0] p;
    p = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    in_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      send_request(1'b0, 2'($urandom), 3'($urandom), 1'($urandom), 1'($urandom), step_done);
    end else begin
      cut = (kind == 1) ? $urandom_range(0, 4) : 1000;
      send_request(1'b1, 2'($urandom), p, 1'($urandom), 1'($urandom), step_done);
      while (!step_done && cut > 0) begin
        send_request(1'b0, 2'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
                     step_done);
        cut--;
      end
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_settings();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_wdata <= regs[i];
      @(posedge clk);
      board.set_reg(i[2:0], regs[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    bit          step_done;
    int unsigned budget;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings
    send_request(1'b0, ssps_pkg::MODE_CAL, 3'd1, 1'b0, 1'b0, step_done);
    run_full(ssps_pkg::MODE_CAL, 3'd1, 1'b0, 1'b0);
    send_request(1'b0, ssps_pkg::MODE_RTT, 3'd2, 1'b1, 1'b1, step_done);
    run_full(ssps_pkg::MODE_RTT, 3'd4, 1'b1, 1'b1);
    run_full(ssps_pkg::MODE_PBR, 3'd0, 1'b1, 1'b0);
    run_full(ssps_pkg::MODE_RTT_PBR, 3'd1, 1'b0, 1'b1);
    // new step while one is in progress
    send_request(1'b1, ssps_pkg::MODE_CAL, 3'd2, 1'b0, 1'b0, step_done);
    send_request(1'b0, ssps_pkg::MODE_CAL, 3'd2, 1'b0, 1'b0, step_done);
    run_full(ssps_pkg::MODE_RTT, 3'd7, 1'b1, 1'b1);
    settle();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          regs[ssps_pkg::CFG_ROLE]        = 8'd1;
          regs[ssps_pkg::CFG_IP1]         = 8'd145;
          regs[ssps_pkg::CFG_IP2]         = 8'd145;
          regs[ssps_pkg::CFG_FCS]         = 8'd150;
          regs[ssps_pkg::CFG_TONE_PERIOD] = 8'd40;
          regs[ssps_pkg::CFG_SWITCH]      = 8'd10;
          regs[ssps_pkg::CFG_SYNC]        = 8'd127;
          regs[ssps_pkg::CFG_SEQUENCE]    = 8'd64;
        end
        1: foreach (regs[i]) regs[i] = 8'd0;
        2: begin
          // full register widths, gaps saturate
          regs[ssps_pkg::CFG_ROLE]        = 8'd1;
          regs[ssps_pkg::CFG_IP1]         = 8'd255;
          regs[ssps_pkg::CFG_IP2]         = 8'd255;
          regs[ssps_pkg::CFG_FCS]         = 8'd255;
          regs[ssps_pkg::CFG_TONE_PERIOD] = 8'd63;
          regs[ssps_pkg::CFG_SWITCH]      = 8'd15;
          regs[ssps_pkg::CFG_SYNC]        = 8'd127;
          regs[ssps_pkg::CFG_SEQUENCE]    = 8'd127;
        end
        default: begin
          regs[ssps_pkg::CFG_ROLE]        = 8'($urandom_range(0, 1));
          regs[ssps_pkg::CFG_IP1]         = 8'($urandom_range(0, 145));
          regs[ssps_pkg::CFG_IP2]         = 8'($urandom_range(0, 145));
          regs[ssps_pkg::CFG_FCS]         = 8'($urandom_range(0, 150));
          regs[ssps_pkg::CFG_TONE_PERIOD] = 8'($urandom_range(0, 40));
          regs[ssps_pkg::CFG_SWITCH]      = 8'($urandom_range(0, 10));
          regs[ssps_pkg::CFG_SYNC]        = 8'($urandom_range(0, 127));
          regs[ssps_pkg::CFG_SEQUENCE]    = 8'($urandom_range(0, 64));
        end
      endcase
      write_settings();
      calm = (phase == 6);
      budget = requests_sent + 250;
      while (requests_sent < budget) run_step();
      settle();
    end

    if (board.failures == 0 && board.outstanding() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
